@@ sv/tmpq_pkg.sv @@
`timescale 1ns / 1ps

package tmpq_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int COUNT_BITS = 8;
    localparam int CFG_BITS = 8;
    localparam int REG_COUNT = 7;
    localparam int INDEX_BITS = $clog2(REG_COUNT);
    localparam int WINDOW_DEPTH = 3;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CFG_BITS-1:0] cfg_t;
    typedef sample_t [WINDOW_DEPTH-1:0] window_t;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_SETTLE      = 3'd0,
        REG_STABLE      = 3'd1,
        REG_CONTROL_ROW = 3'd2,
        REG_DIGIT_ROW   = 3'd3,
        REG_PLUS        = 3'd4,
        REG_MINUS       = 3'd5,
        REG_OK          = 3'd6
    } reg_index_t;

    typedef enum logic [2:0] {
        ZONE_NONE   = 3'd0,
        ZONE_PLUS   = 3'd1,
        ZONE_MINUS  = 3'd2,
        ZONE_OK     = 3'd3,
        ZONE_CANCEL = 3'd4,
        ZONE_DIGIT  = 3'd5
    } zone_t;

    localparam cfg_t SETTLE_RESET      = 8'd20;
    localparam cfg_t STABLE_RESET      = 8'd40;
    localparam cfg_t CONTROL_ROW_RESET = 8'd71;
    localparam cfg_t DIGIT_ROW_RESET   = 8'd181;
    localparam cfg_t PLUS_RESET        = 8'd71;
    localparam cfg_t MINUS_RESET       = 8'd124;
    localparam cfg_t OK_RESET          = 8'd179;

    localparam count_t FILL_COUNT    = count_t'(WINDOW_DEPTH);
    localparam count_t COUNT_MAX     = {COUNT_BITS{1'b1}};
    localparam count_t COUNT_RESTART = count_t'(WINDOW_DEPTH);

endpackage

@@ sv/tmpq_sort3.sv @@
`timescale 1ns / 1ps

module tmpq_sort3
    import tmpq_pkg::*;
(
    input  window_t window,
    input  sample_t fresh,
    output window_t sorted
);

    window_t stage_a;
    window_t stage_b;

    // Entry 0 takes the new sample, then the pairs (0,1), (0,2), (1,2) are ordered.
    always_comb
    begin
        stage_a = window;
        stage_a[0] = fresh;
        if (stage_a[1] < stage_a[0])
        begin
            stage_a[0] = window[1];
            stage_a[1] = fresh;
        end

        stage_b = stage_a;
        if (stage_a[2] < stage_a[0])
        begin
            stage_b[0] = stage_a[2];
            stage_b[2] = stage_a[0];
        end

        sorted = stage_b;
        if (stage_b[2] < stage_b[1])
        begin
            sorted[1] = stage_b[2];
            sorted[2] = stage_b[1];
        end
    end

endmodule

@@ sv/touch_median_press_qualifier.sv @@
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                    | Word
// ---------+-----------+------------------------------+---------------------------------------
// sample   | in        | sample_valid / sample_ready  | pen_down, x_sample, y_sample
// result   | out       | result_valid / result_ready  | press_valid, x_coord, y_coord, zone
// cfg      | in        | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// One sample word is taken per cycle unless stalled; its result word is valid next cycle.
// The median network, counters and zone decode sit between the sample handshake and
// the result register, so that register alone sets the latency.
// The sample side stalls only while a result word waits and result_ready is low.
// cfg_ready is always high. Reset clears the counters, references, flag and result_valid.

module touch_median_press_qualifier
    import tmpq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  logic                  pen_down,
    input  sample_t               x_sample,
    input  sample_t               y_sample,

    output logic                  result_valid,
    input  logic                  result_ready,
    output logic                  press_valid,
    output sample_t               x_coord,
    output sample_t               y_coord,
    output logic [2:0]            zone,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [INDEX_BITS-1:0] cfg_index,
    input  cfg_t                  cfg_data
);

    cfg_t    cfg_reg [REG_COUNT];

    count_t  reading_count_reg;
    count_t  reading_count_next;
    count_t  match_count_reg;
    count_t  match_count_next;
    sample_t x_reference_reg;
    sample_t x_reference_next;
    sample_t y_reference_reg;
    sample_t y_reference_next;
    logic    qualified_reg;
    logic    qualified_next;
    window_t x_window_reg;
    window_t x_window_next;
    window_t y_window_reg;
    window_t y_window_next;

    window_t x_sorted;
    window_t y_sorted;
    zone_t   zone_next;

    logic    result_valid_reg;
    logic    press_valid_reg;
    sample_t x_coord_reg;
    sample_t y_coord_reg;
    zone_t   zone_reg;

    logic    take;

    assign cfg_ready    = 1'b1;
    assign sample_ready = !result_valid_reg || result_ready;
    assign take         = sample_valid && sample_ready;

    tmpq_sort3 u_x_sort
    (
        .window (x_window_reg),
        .fresh  (x_sample),
        .sorted (x_sorted)
    );

    tmpq_sort3 u_y_sort
    (
        .window (y_window_reg),
        .fresh  (y_sample),
        .sorted (y_sorted)
    );

    always_comb
    begin
        reading_count_next = reading_count_reg;
        match_count_next   = match_count_reg;
        x_reference_next   = x_reference_reg;
        y_reference_next   = y_reference_reg;
        qualified_next     = qualified_reg;
        x_window_next      = x_window_reg;
        y_window_next      = y_window_reg;

        if (pen_down && !qualified_reg && (x_sample != '0) && (y_sample != '0))
        begin
            reading_count_next = reading_count_reg + count_t'(1);
            if (reading_count_reg < FILL_COUNT)
            begin
                x_window_next[reading_count_reg[1:0]] = x_sample;
                y_window_next[reading_count_reg[1:0]] = y_sample;
                match_count_next = '0;
                x_reference_next = '0;
                y_reference_next = '0;
            end
            else
            begin
                x_window_next = x_sorted;
                y_window_next = y_sorted;
                if (reading_count_next > cfg_reg[REG_SETTLE])
                begin
                    // The axes are swapped when the references are taken.
                    if (y_reference_reg == '0)
                    begin
                        y_reference_next = x_sorted[1];
                    end
                    if (x_reference_reg == '0)
                    begin
                        x_reference_next = y_sorted[1];
                    end
                    if ((x_sorted[1] == y_reference_next) && (y_sorted[1] == x_reference_next))
                    begin
                        match_count_next = match_count_reg + count_t'(1);
                    end
                    if (match_count_next == cfg_reg[REG_STABLE])
                    begin
                        qualified_next = 1'b1;
                        if (reading_count_next == COUNT_MAX)
                        begin
                            reading_count_next = COUNT_RESTART;
                        end
                    end
                end
            end
        end

        if (!pen_down)
        begin
            reading_count_next = '0;
            qualified_next     = 1'b0;
        end
    end

    always_comb
    begin
        zone_next = ZONE_NONE;
        if (qualified_next)
        begin
            if (y_reference_next < cfg_reg[REG_CONTROL_ROW])
            begin
                if (x_reference_next < cfg_reg[REG_PLUS])
                begin
                    zone_next = ZONE_PLUS;
                end
                else if (x_reference_next < cfg_reg[REG_MINUS])
                begin
                    zone_next = ZONE_MINUS;
                end
                else if (x_reference_next < cfg_reg[REG_OK])
                begin
                    zone_next = ZONE_OK;
                end
                else
                begin
                    zone_next = ZONE_CANCEL;
                end
            end
            else if (y_reference_next < cfg_reg[REG_DIGIT_ROW])
            begin
                zone_next = ZONE_DIGIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_SETTLE]      <= SETTLE_RESET;
            cfg_reg[REG_STABLE]      <= STABLE_RESET;
            cfg_reg[REG_CONTROL_ROW] <= CONTROL_ROW_RESET;
            cfg_reg[REG_DIGIT_ROW]   <= DIGIT_ROW_RESET;
            cfg_reg[REG_PLUS]        <= PLUS_RESET;
            cfg_reg[REG_MINUS]       <= MINUS_RESET;
            cfg_reg[REG_OK]          <= OK_RESET;
        end
        else if (cfg_valid && (cfg_index < INDEX_BITS'(REG_COUNT)))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reading_count_reg <= '0;
            match_count_reg   <= '0;
            x_reference_reg   <= '0;
            y_reference_reg   <= '0;
            qualified_reg     <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                reading_count_reg <= reading_count_next;
                match_count_reg   <= match_count_next;
                x_reference_reg   <= x_reference_next;
                y_reference_reg   <= y_reference_next;
                qualified_reg     <= qualified_next;
                result_valid_reg  <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_window_reg    <= x_window_next;
            y_window_reg    <= y_window_next;
            press_valid_reg <= qualified_next;
            x_coord_reg     <= x_reference_next;
            y_coord_reg     <= y_reference_next;
            zone_reg        <= zone_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign press_valid  = press_valid_reg;
    assign x_coord      = x_coord_reg;
    assign y_coord      = y_coord_reg;
    assign zone         = zone_reg;

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready && !pen_down)
        |=> (result_valid && !press_valid && (zone == ZONE_NONE)))
        else $error("released panel did not clear the press");

    a_zone_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (zone != ZONE_NONE)) |-> press_valid)
        else $error("zone reported without a qualified press");

    a_qualified_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        qualified_reg |-> (reading_count_reg >= FILL_COUNT))
        else $error("press qualified during the fill phase");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> (result_valid && !result_ready))
        else $error("sample side stalled without a waiting result");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import tmpq_pkg::*;

    localparam int ITEM_TARGET = 1450;
    localparam int PHASE_ITEMS = 160;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int FIRST_SPLIT = 480;
    localparam int SECOND_SPLIT = 960;
    localparam int LIGHT_IDLE = 24;
    localparam int HEAVY_IDLE = 72;
    localparam logic [INDEX_BITS-1:0] REG_UNUSED = INDEX_BITS'(REG_COUNT);
    localparam sample_t SAMPLE_TOP = {SAMPLE_BITS{1'b1}};

    typedef struct packed {
        logic    press_valid;
        sample_t x_coord;
        sample_t y_coord;
        zone_t   zone;
    } press_word_t;

    typedef enum logic {
        ROW_READ,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic                  pen;
        sample_t               xs;
        sample_t               ys;
        int                    reps;
        logic [INDEX_BITS-1:0] idx;
        cfg_t                  data;
        bit                    typed;
        press_word_t           want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_ready;
    logic                  pen_down = 1'b0;
    sample_t               x_sample = '0;
    sample_t               y_sample = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic                  press_valid;
    sample_t               x_coord;
    sample_t               y_coord;
    logic [2:0]            zone;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [INDEX_BITS-1:0] cfg_index = '0;
    cfg_t                  cfg_data = '0;

    count_t  n_readings = '0;
    window_t x_win = '0;
    window_t y_win = '0;
    sample_t x_ref = '0;
    sample_t y_ref = '0;
    count_t  n_matches = '0;
    logic    locked = 1'b0;
    cfg_t    regs_m [REG_COUNT];

    press_word_t due_words[$];
    plan_row_t   plan[$];
    int          n_effective = 0;
    int          n_sent = 0;
    int          n_failures = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = LIGHT_IDLE;
    int          recv_idle_pct = HEAVY_IDLE;

    touch_median_press_qualifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .pen_down     (pen_down),
        .x_sample     (x_sample),
        .y_sample     (y_sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .press_valid  (press_valid),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .zone         (zone),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic window_t sorted_window(input window_t w, input sample_t fresh);
        sample_t t;
        w[0] = fresh;
        if (w[1] < w[0])
        begin
            t = w[0];
            w[0] = w[1];
            w[1] = t;
        end
        if (w[2] < w[0])
        begin
            t = w[0];
            w[0] = w[2];
            w[2] = t;
        end
        if (w[2] < w[1])
        begin
            t = w[1];
            w[1] = w[2];
            w[2] = t;
        end
        return w;
    endfunction

    function automatic press_word_t advance_panel(input logic pen, input sample_t xs,
                                                  input sample_t ys, output bit took_effect);
        press_word_t word;
        took_effect = !pen;
        if (pen && !locked && xs != 0 && ys != 0)
        begin
            took_effect = 1'b1;
            if (n_readings < FILL_COUNT)
            begin
                x_win[n_readings[1:0]] = xs;
                y_win[n_readings[1:0]] = ys;
                n_readings = n_readings + 1'b1;
                n_matches = '0;
                x_ref = '0;
                y_ref = '0;
            end
            else
            begin
                n_readings = n_readings + 1'b1;
                x_win = sorted_window(x_win, xs);
                y_win = sorted_window(y_win, ys);
                if (n_readings > regs_m[REG_SETTLE])
                begin
                    if (y_ref == 0)
                        y_ref = x_win[1];
                    if (x_ref == 0)
                        x_ref = y_win[1];
                    if (x_win[1] == y_ref && y_win[1] == x_ref)
                        n_matches = n_matches + 1'b1;
                    if (n_matches == regs_m[REG_STABLE])
                    begin
                        locked = 1'b1;
                        if (n_readings == COUNT_MAX)
                            n_readings = COUNT_RESTART;
                    end
                end
            end
        end
        if (!pen)
        begin
            n_readings = '0;
            locked = 1'b0;
        end
        word.press_valid = locked;
        word.x_coord = x_ref;
        word.y_coord = y_ref;
        word.zone = ZONE_NONE;
        if (locked)
        begin
            if (y_ref < regs_m[REG_CONTROL_ROW])
            begin
                if (x_ref < regs_m[REG_PLUS])
                    word.zone = ZONE_PLUS;
                else if (x_ref < regs_m[REG_MINUS])
                    word.zone = ZONE_MINUS;
                else if (x_ref < regs_m[REG_OK])
                    word.zone = ZONE_OK;
                else
                    word.zone = ZONE_CANCEL;
            end
            else if (y_ref < regs_m[REG_DIGIT_ROW])
                word.zone = ZONE_DIGIT;
        end
        return word;
    endfunction

    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return sample_t'(1);
        if (r == 1)
            return SAMPLE_TOP;
        return sample_t'($urandom_range(1, 255));
    endfunction

    function automatic void plan_read(input logic pen, input sample_t xs, input sample_t ys,
                                      input int reps, input bit typed, input logic pv,
                                      input sample_t xc, input sample_t yc, input zone_t z);
        plan_row_t row;
        row.kind = ROW_READ;
        row.pen = pen;
        row.xs = xs;
        row.ys = ys;
        row.reps = reps;
        row.idx = '0;
        row.data = '0;
        row.typed = typed;
        row.want.press_valid = pv;
        row.want.x_coord = xc;
        row.want.y_coord = yc;
        row.want.zone = z;
        plan.push_back(row);
    endfunction

    function automatic void plan_write(input logic [INDEX_BITS-1:0] idx, input cfg_t data);
        plan_row_t row;
        row.kind = ROW_WRITE;
        row.pen = 1'b0;
        row.xs = '0;
        row.ys = '0;
        row.reps = 0;
        row.idx = idx;
        row.data = data;
        row.typed = 1'b0;
        row.want = '0;
        plan.push_back(row);
    endfunction

    task automatic send_reading(input logic pen, input sample_t xs, input sample_t ys,
                                input bit typed, input press_word_t want);
        int          gap;
        bit          eff;
        press_word_t word;
        if (n_effective < FIRST_SPLIT)
        begin
            send_idle_pct = LIGHT_IDLE;
            recv_idle_pct = HEAVY_IDLE;
        end
        else if (n_effective < SECOND_SPLIT)
        begin
            send_idle_pct = HEAVY_IDLE;
            recv_idle_pct = LIGHT_IDLE;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        gap = 0;
        while (gap < 10 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        pen_down <= pen;
        x_sample <= xs;
        y_sample <= ys;
        do
            @(posedge clk);
        while (!sample_ready);
        word = advance_panel(pen, xs, ys, eff);
        due_words.push_back(typed ? want : word);
        n_sent++;
        if (eff)
            n_effective++;
    endtask

    task automatic write_setting(input logic [INDEX_BITS-1:0] idx, input cfg_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < REG_COUNT)
            regs_m[idx] = data;
    endtask

    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        press_word_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (due_words.size() == 0)
            begin
                $error("result word arrived with nothing expected");
                n_failures++;
            end
            else
            begin
                want = due_words.pop_front();
                if (press_valid !== want.press_valid)
                begin
                    $error("press_valid: expected %0d, got %0d", want.press_valid, press_valid);
                    n_failures++;
                end
                if (x_coord !== want.x_coord)
                begin
                    $error("x_coord: expected %0d, got %0d", want.x_coord, x_coord);
                    n_failures++;
                end
                if (y_coord !== want.y_coord)
                begin
                    $error("y_coord: expected %0d, got %0d", want.y_coord, y_coord);
                    n_failures++;
                end
                if (zone !== want.zone)
                begin
                    $error("zone: expected %0d, got %0d", want.zone, zone);
                    n_failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int      i;
        int      k;
        int      r;
        int      len;
        int      phase;
        int      phase_start;
        int      stable_eff;
        logic    pen;
        sample_t bx;
        sample_t by;
        sample_t sx;
        sample_t sy;
        cfg_t    vals [REG_COUNT];

        regs_m[REG_SETTLE] = SETTLE_RESET;
        regs_m[REG_STABLE] = STABLE_RESET;
        regs_m[REG_CONTROL_ROW] = CONTROL_ROW_RESET;
        regs_m[REG_DIGIT_ROW] = DIGIT_ROW_RESET;
        regs_m[REG_PLUS] = PLUS_RESET;
        regs_m[REG_MINUS] = MINUS_RESET;
        regs_m[REG_OK] = OK_RESET;

        plan_read(1'b0, 0, 0, 1, 1'b1, 1'b0, 0, 0, ZONE_NONE);
        plan_read(1'b1, 0, 200, 1, 1'b1, 1'b0, 0, 0, ZONE_NONE);
        plan_read(1'b1, 200, 0, 1, 1'b1, 1'b0, 0, 0, ZONE_NONE);
        plan_write(REG_SETTLE, 3);
        plan_write(REG_STABLE, 2);
        plan_read(1'b1, SAMPLE_TOP, 1, 3, 1'b1, 1'b0, 0, 0, ZONE_NONE);
        plan_read(1'b1, SAMPLE_TOP, 1, 1, 1'b1, 1'b0, 1, SAMPLE_TOP, ZONE_NONE);
        plan_read(1'b1, SAMPLE_TOP, 1, 1, 1'b1, 1'b1, 1, SAMPLE_TOP, ZONE_NONE);
        plan_read(1'b1, 9, 9, 1, 1'b1, 1'b1, 1, SAMPLE_TOP, ZONE_NONE);
        plan_read(1'b0, SAMPLE_TOP, SAMPLE_TOP, 1, 1'b1, 1'b0, 1, SAMPLE_TOP, ZONE_NONE);
        plan_read(1'b1, 10, 10, 5, 1'b1, 1'b1, 10, 10, ZONE_PLUS);
        plan_read(1'b0, 0, 0, 1, 1'b0, 1'b0, 0, 0, ZONE_NONE);
        plan_read(1'b1, 10, 100, 5, 1'b1, 1'b1, 100, 10, ZONE_MINUS);
        plan_read(1'b0, 0, 0, 1, 1'b0, 1'b0, 0, 0, ZONE_NONE);
        plan_read(1'b1, 10, 150, 5, 1'b1, 1'b1, 150, 10, ZONE_OK);
        plan_read(1'b0, 0, 0, 1, 1'b0, 1'b0, 0, 0, ZONE_NONE);
        plan_read(1'b1, 10, 200, 5, 1'b1, 1'b1, 200, 10, ZONE_CANCEL);
        plan_read(1'b0, 0, 0, 1, 1'b0, 1'b0, 0, 0, ZONE_NONE);
        plan_read(1'b1, 100, 50, 5, 1'b1, 1'b1, 50, 100, ZONE_DIGIT);
        plan_read(1'b0, 0, 0, 1, 1'b0, 1'b0, 0, 0, ZONE_NONE);
        // With a stable count of zero the press qualifies only when the match count wraps.
        plan_write(REG_STABLE, 0);
        plan_read(1'b1, 77, 33, 259, 1'b0, 1'b0, 0, 0, ZONE_NONE);
        plan_read(1'b0, 0, 0, 1, 1'b0, 1'b0, 0, 0, ZONE_NONE);
        plan_write(REG_SETTLE, 254);
        plan_write(REG_STABLE, 1);
        plan_read(1'b1, 50, 60, 255, 1'b1, 1'b1, 60, 50, ZONE_PLUS);
        plan_read(1'b0, 0, 0, 1, 1'b0, 1'b0, 0, 0, ZONE_NONE);
        // The reading count wraps and a new fill starts.
        plan_write(REG_SETTLE, 255);
        plan_read(1'b1, 130, 140, 262, 1'b0, 1'b0, 0, 0, ZONE_NONE);
        plan_read(1'b0, 0, 0, 1, 1'b0, 1'b0, 0, 0, ZONE_NONE);
        plan_write(REG_UNUSED, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < plan.size(); i++)
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                if (i == 0 || plan[i-1].kind != ROW_WRITE)
                    wait_idle();
                write_setting(plan[i].idx, plan[i].data);
                if (i + 1 == plan.size() || plan[i+1].kind != ROW_WRITE)
                    cfg_valid <= 1'b0;
            end
            else
            begin
                for (k = 0; k < plan[i].reps; k++)
                    send_reading(plan[i].pen, plan[i].xs, plan[i].ys,
                                 plan[i].typed && (k + 1 == plan[i].reps), plan[i].want);
            end
        end

        phase = 0;
        while (n_sent < ITEM_TARGET)
        begin
            wait_idle();
            for (r = 0; r < REG_COUNT; r++)
                vals[r] = cfg_t'($urandom_range(0, 255));
            case (phase)
                0:
                begin
                    for (r = 0; r < REG_COUNT; r++)
                        vals[r] = '0;
                    vals[REG_STABLE] = 1;
                end
                1:
                begin
                    for (r = 0; r < REG_COUNT; r++)
                        vals[r] = '1;
                    vals[REG_SETTLE] = '0;
                end
                2:
                begin
                    vals[REG_SETTLE] = '1;
                    vals[REG_STABLE] = 1;
                end
                default:
                begin
                    vals[REG_SETTLE] = cfg_t'($urandom_range(0, 12));
                    vals[REG_STABLE] = cfg_t'($urandom_range(1, 16));
                end
            endcase
            for (r = 0; r < REG_COUNT; r++)
                write_setting(INDEX_BITS'(r), vals[r]);
            if ($urandom_range(0, 3) == 0)
                write_setting(REG_UNUSED, cfg_t'($urandom_range(0, 255)));
            cfg_valid <= 1'b0;

            phase_start = n_effective;
            while (n_effective - phase_start < PHASE_ITEMS && n_sent < ITEM_TARGET)
            begin
                bx = pick_sample();
                by = pick_sample();
                stable_eff = (regs_m[REG_STABLE] == 0) ? 256 : regs_m[REG_STABLE];
                len = regs_m[REG_SETTLE] + stable_eff + 3 + $urandom_range(0, 8);
                if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(1, len);
                for (k = 0; k < len; k++)
                begin
                    pen = 1'b1;
                    sx = bx;
                    sy = by;
                    r = $urandom_range(0, 99);
                    if (r >= 97)
                    begin
                        sx = sample_t'($urandom_range(0, 255));
                        sy = sample_t'($urandom_range(0, 255));
                    end
                    else if (r >= 94 && len < 64)
                    begin
                        pen = 1'b0;
                        sx = sample_t'($urandom_range(0, 255));
                        sy = sample_t'($urandom_range(0, 255));
                    end
                    else if (r >= 88)
                    begin
                        if ($urandom_range(0, 1) == 0)
                        begin
                            sx = '0;
                            sy = sample_t'($urandom_range(0, 255));
                        end
                        else
                        begin
                            sx = sample_t'($urandom_range(0, 255));
                            sy = '0;
                        end
                    end
                    else if (r >= 78)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            sx = pick_sample();
                        else
                            sy = pick_sample();
                    end
                    send_reading(pen, sx, sy, 1'b0, '0);
                end
                if ($urandom_range(0, 6) != 0)
                    send_reading(1'b0, sample_t'($urandom_range(0, 255)),
                                 sample_t'($urandom_range(0, 255)), 1'b0, '0);
                for (k = $urandom_range(0, 2); k > 0; k--)
                    send_reading(1'($urandom_range(0, 1)), sample_t'($urandom_range(0, 255)),
                                 sample_t'($urandom_range(0, 255)), 1'b0, '0);
            end
            phase++;
        end

        sample_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (n_failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
